### rtl/core/pblc_pkg.sv
// ----------------------------------------------------------------------------
// pblc_pkg: shared types and constants for the plane buffer layout calculator
// Holds the configuration register indexes, the fixed metadata alignments,
// the divider widths and status type, and the power-of-two round-up helper.
// ----------------------------------------------------------------------------
package pblc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FRAME_WIDTH     = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT    = 3'd1;
    localparam logic [2:0] CFG_BYTES_PER_PIXEL = 3'd2;
    localparam logic [2:0] CFG_COMPRESSED_MODE = 3'd3;
    localparam logic [2:0] CFG_HALF_HEIGHT     = 3'd4;
    localparam logic [2:0] CFG_SIZE_ALIGN_LG   = 3'd5;

    // Fixed metadata alignments, as log2: 64 blocks wide, 16 blocks high,
    // 4096-byte metadata plane size.
    localparam logic [4:0] META_W_ALIGN_LG    = 5'd6;
    localparam logic [4:0] META_H_ALIGN_LG    = 5'd4;
    localparam logic [4:0] META_SIZE_ALIGN_LG = 5'd12;

    // Block-count divider: a 16-bit dividend covers a 15-bit extent plus a
    // 9-bit block size minus one.
    localparam int DIV_NUM_W = 16;
    localparam int DIV_DEN_W = 9;
    localparam int DIV_CNT_W = 4;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_status_t;

    // Round x up to a multiple of 2**lg, wrapping at 32 bits.
    function automatic logic [31:0] round_up_lg(input logic [31:0] x, input logic [4:0] lg);
        logic [31:0] mask;
        mask = (32'd1 << lg) - 32'd1;
        return (x + mask) & ~mask;
    endfunction

endpackage

### rtl/core/pblc_div.sv
// ----------------------------------------------------------------------------
// pblc_div: iterative restoring divider
// Divides a 16-bit dividend by a nonzero 9-bit divisor, one quotient bit per
// cycle. A start beat loads the operands; done pulses for one cycle when the
// quotient is final, and the quotient holds until the next start.
// ----------------------------------------------------------------------------
module pblc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pblc_pkg::DIV_NUM_W-1:0] num,
    input  logic [pblc_pkg::DIV_DEN_W-1:0] den,
    output pblc_pkg::div_status_t          status
);
    import pblc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] quot_reg, quot_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    // The partial remainder stays below the divisor, so the shifted trial
    // value needs one bit more than the divisor.
    assign trial = {rem_reg, quot_reg[DIV_NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W - 1);
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DIV_NUM_W-2:0], fits};
            rem_next  = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign status.done = done_reg;
    assign status.quot = quot_reg;

endmodule

### rtl/core/plane_buffer_layout_calc_top.sv
// ----------------------------------------------------------------------------
// plane_buffer_layout_calc_top: per-plane buffer layout calculator
// One plane at a time: in_stall is high from an accepted input beat until
// the plane moves into the output register. Each plane makes two block-count
// divisions on the shared 16-step divider and three passes through the
// shared multiplier. A result may wait in the output register while the next
// plane is accepted. Reset (rst_n, asynchronous) restores the register
// defaults and clears the running offset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module plane_buffer_layout_calc_top (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_wdata,

    // Plane description input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  plane_index,
    input  logic [3:0]  pitch_align_log2,
    input  logic [3:0]  height_align_log2,
    input  logic [3:0]  meta_pitch_align_log2,
    input  logic [3:0]  meta_height_align_log2,
    input  logic [4:0]  meta_size_align_log2,
    input  logic [8:0]  blk_width,
    input  logic [8:0]  blk_height,
    input  logic        last_plane,

    // Plane layout result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] aligned_width,
    output logic [31:0] aligned_height,
    output logic [31:0] stride,
    output logic [31:0] data_bytes,
    output logic [31:0] meta_size,
    output logic [31:0] byte_offset,
    output logic [31:0] total_size,
    output logic        is_last
);
    import pblc_pkg::*;

    // The sequencer walks one plane through the shared units: two divisions
    // for the metadata block counts, then three multiply and round-up pairs
    // for stride, data size and metadata size, then the offset update.
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_DIVW  = 10'b00_0000_0010,
        ST_DIVH  = 10'b00_0000_0100,
        ST_MUL_S = 10'b00_0000_1000,
        ST_RND_S = 10'b00_0001_0000,
        ST_MUL_D = 10'b00_0010_0000,
        ST_RND_D = 10'b00_0100_0000,
        ST_MUL_M = 10'b00_1000_0000,
        ST_RND_M = 10'b01_0000_0000,
        ST_OUT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [14:0] frame_width_reg, frame_width_next;
    logic [14:0] frame_height_reg, frame_height_next;
    logic [3:0]  bpp_reg, bpp_next;
    logic        compressed_reg, compressed_next;
    logic        half_height_reg, half_height_next;
    logic [4:0]  size_align_reg, size_align_next;

    // Running byte offset of the next plane.
    logic [31:0] running_offset_reg, running_offset_next;

    // Per-plane working registers.
    logic [15:0] aw_reg, aw_next;
    logic [15:0] ah_reg, ah_next;
    logic [14:0] height_reg, height_next;
    logic [8:0]  bh_reg, bh_next;
    logic [3:0]  pitch_lg_reg, pitch_lg_next;
    logic [4:0]  size_lg_reg, size_lg_next;
    logic        last_reg, last_next;
    logic [16:0] mw_reg, mw_next;
    logic [16:0] mh_reg, mh_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] stride_reg, stride_next;
    logic [31:0] dsize_reg, dsize_next;
    logic [31:0] msize_reg, msize_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [31:0] o_aw_reg, o_ah_reg, o_stride_reg, o_dsize_reg;
    logic [31:0] o_msize_reg, o_offset_reg, o_total_reg;
    logic        o_last_reg;

    logic        in_accept;
    logic        out_load;
    logic [8:0]  bw_eff;
    logic [8:0]  bh_eff;
    logic [15:0] h_plus;
    logic [14:0] plane_lines;
    logic [3:0]  pitch_lg_sel;
    logic [3:0]  height_lg_sel;
    logic [31:0] aw_full;
    logic [31:0] ah_full;
    logic [31:0] quot_rnd;
    logic [4:0]  quot_lg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_full;
    logic [4:0]  rnd_lg;
    logic [31:0] rnd_out;
    logic [31:0] offset_sum;

    logic                          div_start;
    logic [DIV_NUM_W-1:0]          div_num;
    logic [DIV_DEN_W-1:0]          div_den;
    div_status_t                   div_stat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // A finished plane moves into the output register when it is empty or
    // its beat is being taken in the same cycle.
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        bpp_next          = bpp_reg;
        compressed_next   = compressed_reg;
        half_height_next  = half_height_reg;
        size_align_next   = size_align_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:     frame_width_next  = cfg_wdata;
                CFG_FRAME_HEIGHT:    frame_height_next = cfg_wdata;
                CFG_BYTES_PER_PIXEL: bpp_next          = cfg_wdata[3:0];
                CFG_COMPRESSED_MODE: compressed_next   = cfg_wdata[0];
                CFG_HALF_HEIGHT:     half_height_next  = cfg_wdata[0];
                CFG_SIZE_ALIGN_LG:   size_align_next   = cfg_wdata[4:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Plane setup on the accepted input beat.
    // ------------------------------------------------------------------
    // A block dimension of zero counts as one.
    assign bw_eff = (blk_width == '0) ? 9'd1 : blk_width;
    assign bh_eff = (blk_height == '0) ? 9'd1 : blk_height;

    // Chroma planes may take half the frame height, rounded up.
    assign h_plus      = {1'b0, frame_height_reg} + 16'd1;
    assign plane_lines = ((plane_index != 2'd0) && half_height_reg) ? h_plus[15:1]
                                                                     : frame_height_reg;

    assign pitch_lg_sel  = compressed_reg ? meta_pitch_align_log2 : pitch_align_log2;
    assign height_lg_sel = compressed_reg ? meta_height_align_log2 : height_align_log2;

    assign aw_full = round_up_lg({17'd0, frame_width_reg}, {1'b0, pitch_lg_sel});
    assign ah_full = round_up_lg({17'd0, plane_lines}, {1'b0, height_lg_sel});

    // ------------------------------------------------------------------
    // Shared divider: ceil(width / block width), then ceil(height / block height).
    // ------------------------------------------------------------------
    always_comb
    begin
        div_start = 1'b0;
        div_num   = 16'({1'b0, frame_width_reg}) + 16'(bw_eff) - 16'd1;
        div_den   = bw_eff;
        if (state_reg == ST_DIVW)
        begin
            div_start = div_stat.done;
            div_num   = 16'(height_reg) + 16'(bh_reg) - 16'd1;
            div_den   = bh_reg;
        end
        else if (in_accept)
        begin
            div_start = 1'b1;
        end
    end

    pblc_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_stat)
    );

    // Block counts round up to 64 across and 16 down.
    assign quot_lg  = (state_reg == ST_DIVW) ? META_W_ALIGN_LG : META_H_ALIGN_LG;
    assign quot_rnd = round_up_lg({16'd0, div_stat.quot}, quot_lg);

    // ------------------------------------------------------------------
    // Shared multiplier and round-up unit. The product is registered before
    // it is rounded.
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = {15'd0, mw_reg};
        mul_b = {15'd0, mh_reg};
        case (state_reg)
            ST_MUL_S:
            begin
                mul_a = {16'd0, aw_reg};
                mul_b = {28'd0, bpp_reg};
            end
            ST_MUL_D:
            begin
                mul_a = stride_reg;
                mul_b = {16'd0, ah_reg};
            end
            default:
            begin
                mul_a = {15'd0, mw_reg};
                mul_b = {15'd0, mh_reg};
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    always_comb
    begin
        case (state_reg)
            ST_RND_S: rnd_lg = {1'b0, pitch_lg_reg};
            ST_RND_D: rnd_lg = size_lg_reg;
            default:  rnd_lg = META_SIZE_ALIGN_LG;
        endcase
    end

    assign rnd_out = round_up_lg(prod_reg, rnd_lg);

    // Offset of the plane after this one; all sums wrap at 32 bits.
    assign offset_sum = running_offset_reg + dsize_reg + msize_reg;

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next          = state_reg;
        running_offset_next = running_offset_reg;
        aw_next             = aw_reg;
        ah_next             = ah_reg;
        height_next         = height_reg;
        bh_next             = bh_reg;
        pitch_lg_next       = pitch_lg_reg;
        size_lg_next        = size_lg_reg;
        last_next           = last_reg;
        mw_next             = mw_reg;
        mh_next             = mh_reg;
        prod_next           = prod_reg;
        stride_next         = stride_reg;
        dsize_next          = dsize_reg;
        msize_next          = msize_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    aw_next       = aw_full[15:0];
                    ah_next       = ah_full[15:0];
                    height_next   = plane_lines;
                    bh_next       = bh_eff;
                    pitch_lg_next = pitch_lg_sel;
                    size_lg_next  = compressed_reg ? meta_size_align_log2 : size_align_reg;
                    last_next     = last_plane;
                    state_next    = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (div_stat.done)
                begin
                    mw_next    = quot_rnd[16:0];
                    state_next = ST_DIVH;
                end
            end
            ST_DIVH:
            begin
                if (div_stat.done)
                begin
                    mh_next    = quot_rnd[16:0];
                    state_next = ST_MUL_S;
                end
            end
            ST_MUL_S:
            begin
                prod_next  = mul_full[31:0];
                state_next = ST_RND_S;
            end
            ST_RND_S:
            begin
                stride_next = rnd_out;
                state_next  = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                prod_next  = mul_full[31:0];
                state_next = ST_RND_D;
            end
            ST_RND_D:
            begin
                dsize_next = rnd_out;
                state_next = ST_MUL_M;
            end
            ST_MUL_M:
            begin
                prod_next  = mul_full[31:0];
                state_next = ST_RND_M;
            end
            ST_RND_M:
            begin
                // Without compression there is no metadata plane.
                msize_next = compressed_reg ? rnd_out : 32'd0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    running_offset_next = last_reg ? 32'd0 : offset_sum;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set when a plane is loaded, cleared when its beat is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            frame_width_reg    <= 15'd1920;
            frame_height_reg   <= 15'd1080;
            bpp_reg            <= 4'd1;
            compressed_reg     <= 1'b0;
            half_height_reg    <= 1'b0;
            size_align_reg     <= 5'd12;
            running_offset_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            frame_width_reg    <= frame_width_next;
            frame_height_reg   <= frame_height_next;
            bpp_reg            <= bpp_next;
            compressed_reg     <= compressed_next;
            half_height_reg    <= half_height_next;
            size_align_reg     <= size_align_next;
            running_offset_reg <= running_offset_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        aw_reg       <= aw_next;
        ah_reg       <= ah_next;
        height_reg   <= height_next;
        bh_reg       <= bh_next;
        pitch_lg_reg <= pitch_lg_next;
        size_lg_reg  <= size_lg_next;
        last_reg     <= last_next;
        mw_reg       <= mw_next;
        mh_reg       <= mh_next;
        prod_reg     <= prod_next;
        stride_reg   <= stride_next;
        dsize_reg    <= dsize_next;
        msize_reg    <= msize_next;
        if (out_load)
        begin
            o_aw_reg     <= {16'd0, aw_reg};
            o_ah_reg     <= {16'd0, ah_reg};
            o_stride_reg <= stride_reg;
            o_dsize_reg  <= dsize_reg;
            o_msize_reg  <= msize_reg;
            o_offset_reg <= running_offset_reg;
            o_total_reg  <= last_reg ? offset_sum : 32'd0;
            o_last_reg   <= last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign aligned_width  = o_aw_reg;
    assign aligned_height = o_ah_reg;
    assign stride         = o_stride_reg;
    assign data_bytes     = o_dsize_reg;
    assign meta_size      = o_msize_reg;
    assign byte_offset    = o_offset_reg;
    assign total_size     = o_total_reg;
    assign is_last        = o_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIVW || state_reg == ST_DIVH))
        else $error("divider finished outside a division step");

    a_offset_cleared_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_reg) |=> (running_offset_reg == 32'd0))
        else $error("running offset not cleared after the last plane");

    a_no_meta_uncompressed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !compressed_reg) |=> (meta_size == 32'd0))
        else $error("metadata size nonzero in uncompressed mode");

    a_total_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !last_reg) |=> (total_size == 32'd0 && !is_last))
        else $error("total size given on a plane that is not last");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the plane buffer layout calculator
// Plane descriptions are driven as beats with random gaps and the result
// channel is stalled at random. A scoreboard predicts each plane's aligned
// sizes, metadata size, offset and buffer total, and checks every result beat
// in order. A directed part hits the field and register extremes and the
// special cases, then about 1600 random planes run under varied settings.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pblc_pkg::*;

    // Cycles without any accepted beat before the run is declared hung. The
    // longest legal quiet stretch is a full latency plus a stall, a gap and a
    // register write sequence, well under this limit.
    localparam int HANG_LIMIT = 1000;

    // One plane description, as it goes onto the input channel.
    typedef struct packed {
        logic [1:0] plane_index;
        logic [3:0] pitch_align_log2;
        logic [3:0] height_align_log2;
        logic [3:0] meta_pitch_align_log2;
        logic [3:0] meta_height_align_log2;
        logic [4:0] meta_size_align_log2;
        logic [8:0] blk_width;
        logic [8:0] blk_height;
        logic       last_plane;
    } plane_t;

    // One plane layout, as it comes off the result channel.
    typedef struct packed {
        logic [31:0] aligned_width;
        logic [31:0] aligned_height;
        logic [31:0] stride;
        logic [31:0] data_bytes;
        logic [31:0] meta_size;
        logic [31:0] byte_offset;
        logic [31:0] total_size;
        logic        is_last;
    } layout_t;

    // The scoreboard keeps its own copy of the registers and of the running
    // offset, works out the layout of every accepted plane and holds those
    // layouts until the matching result beats show up.
    class layout_ledger;
        localparam int REPORT_LIMIT = 10;

        logic [14:0] width_px;
        logic [14:0] height_lines;
        logic [3:0]  bytes_pp;
        logic        compressed;
        logic        half_chroma;
        logic [4:0]  area_align_lg;
        logic [31:0] offset_acc;

        layout_t     pending_layouts[$];
        int          failures;
        int          beats_checked;

        function new();
            width_px      = 15'd1920;
            height_lines  = 15'd1080;
            bytes_pp      = 4'd1;
            compressed    = 1'b0;
            half_chroma   = 1'b0;
            area_align_lg = 5'd12;
            offset_acc    = 32'd0;
            failures      = 0;
            beats_checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [14:0] value);
            case (idx)
                CFG_FRAME_WIDTH:     width_px      = value;
                CFG_FRAME_HEIGHT:    height_lines  = value;
                CFG_BYTES_PER_PIXEL: bytes_pp      = value[3:0];
                CFG_COMPRESSED_MODE: compressed    = value[0];
                CFG_HALF_HEIGHT:     half_chroma   = value[0];
                CFG_SIZE_ALIGN_LG:   area_align_lg = value[4:0];
                default: ;
            endcase
        endfunction

        // Power-of-two round-up; the add wraps at 32 bits like the hardware.
        static function logic [31:0] align_up(logic [31:0] x, logic [4:0] lg);
            logic [31:0] mask;
            mask = (32'd1 << lg) - 32'd1;
            return (x + mask) & ~mask;
        endfunction

        // Layout of one plane; also advances the running offset.
        function layout_t plane_layout(plane_t p);
            layout_t     r;
            logic [31:0] lines;
            logic [31:0] extent;
            logic [31:0] blk_w;
            logic [31:0] blk_h;
            logic [31:0] meta_cols;
            logic [31:0] meta_rows;
            logic [4:0]  pitch_lg;
            logic [4:0]  lines_lg;
            logic [4:0]  area_lg;

            extent = {17'd0, width_px};
            lines  = {17'd0, height_lines};
            if (p.plane_index != 2'd0 && half_chroma)
                lines = (lines + 32'd1) >> 1;

            if (compressed)
            begin
                pitch_lg = {1'b0, p.meta_pitch_align_log2};
                lines_lg = {1'b0, p.meta_height_align_log2};
                area_lg  = p.meta_size_align_log2;
            end
            else
            begin
                pitch_lg = {1'b0, p.pitch_align_log2};
                lines_lg = {1'b0, p.height_align_log2};
                area_lg  = area_align_lg;
            end

            r.aligned_width  = align_up(extent, pitch_lg);
            r.aligned_height = align_up(lines, lines_lg);
            r.stride         = align_up(r.aligned_width * {28'd0, bytes_pp}, pitch_lg);
            r.data_bytes     = align_up(r.stride * r.aligned_height, area_lg);
            r.meta_size      = 32'd0;

            if (compressed)
            begin
                // A block dimension of zero counts as one block pixel.
                blk_w = (p.blk_width == 9'd0) ? 32'd1 : {23'd0, p.blk_width};
                blk_h = (p.blk_height == 9'd0) ? 32'd1 : {23'd0, p.blk_height};
                meta_cols   = align_up((extent + blk_w - 32'd1) / blk_w, META_W_ALIGN_LG);
                meta_rows   = align_up((lines + blk_h - 32'd1) / blk_h, META_H_ALIGN_LG);
                r.meta_size = align_up(meta_cols * meta_rows, META_SIZE_ALIGN_LG);
            end

            r.byte_offset = offset_acc;
            offset_acc    = offset_acc + r.data_bytes + r.meta_size;
            r.total_size  = 32'd0;
            r.is_last     = p.last_plane;
            if (p.last_plane)
            begin
                r.total_size = offset_acc;
                offset_acc   = 32'd0;
            end
            return r;
        endfunction

        function void note_plane(plane_t p);
            pending_layouts.push_back(plane_layout(p));
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("result beat %0d: %s expected 0x%08h, got 0x%08h",
                             beats_checked, field, want, got);
            end
        endfunction

        function void check_layout(layout_t got);
            layout_t want;
            if (pending_layouts.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("result beat %0d arrived with no plane outstanding",
                             beats_checked);
            end
            else
            begin
                want = pending_layouts.pop_front();
                compare_field("aligned_width", want.aligned_width, got.aligned_width);
                compare_field("aligned_height", want.aligned_height, got.aligned_height);
                compare_field("stride", want.stride, got.stride);
                compare_field("data_bytes", want.data_bytes, got.data_bytes);
                compare_field("meta_size", want.meta_size, got.meta_size);
                compare_field("byte_offset", want.byte_offset, got.byte_offset);
                compare_field("total_size", want.total_size, got.total_size);
                compare_field("is_last", {31'd0, want.is_last}, {31'd0, got.is_last});
            end
            beats_checked++;
        endfunction

        function int outstanding();
            return pending_layouts.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  plane_index;
    logic [3:0]  pitch_align_log2;
    logic [3:0]  height_align_log2;
    logic [3:0]  meta_pitch_align_log2;
    logic [3:0]  meta_height_align_log2;
    logic [4:0]  meta_size_align_log2;
    logic [8:0]  blk_width;
    logic [8:0]  blk_height;
    logic        last_plane;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] aligned_width;
    logic [31:0] aligned_height;
    logic [31:0] stride;
    logic [31:0] data_bytes;
    logic [31:0] meta_size;
    logic [31:0] byte_offset;
    logic [31:0] total_size;
    logic        is_last;

    layout_ledger ledger = new();

    // When set, neither side inserts gaps or stalls, so the block runs at
    // its full rate for a while.
    bit steady_flow = 1'b0;

    // Remaining stall cycles to hold against the result beat now on offer.
    int stall_left = 0;

    plane_buffer_layout_calc_top uut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_index              (cfg_index),
        .cfg_wdata              (cfg_wdata),
        .in_valid               (in_valid),
        .in_stall               (in_stall),
        .plane_index            (plane_index),
        .pitch_align_log2       (pitch_align_log2),
        .height_align_log2      (height_align_log2),
        .meta_pitch_align_log2  (meta_pitch_align_log2),
        .meta_height_align_log2 (meta_height_align_log2),
        .meta_size_align_log2   (meta_size_align_log2),
        .blk_width              (blk_width),
        .blk_height             (blk_height),
        .last_plane             (last_plane),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .aligned_width          (aligned_width),
        .aligned_height         (aligned_height),
        .stride                 (stride),
        .data_bytes             (data_bytes),
        .meta_size              (meta_size),
        .byte_offset            (byte_offset),
        .total_size             (total_size),
        .is_last                (is_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Wait drawn at random per beat by either side, none when the flow is
    // meant to be steady.
    function automatic int draw_wait();
        return steady_flow ? 0 : int'($urandom_range(0, 12));
    endfunction

    // Result side. Each new result beat gets a fresh stall count, and the
    // count only runs down while the beat is actually on offer, so the stall
    // really lands on results rather than on empty cycles.
    always @(posedge clk)
    begin : result_stall
        int hold;
        if (out_valid && !out_stall)
        begin
            hold = draw_wait();
            stall_left <= hold;
            out_stall  <= (hold != 0);
        end
        else if (out_valid && out_stall)
        begin
            if (stall_left <= 1)
            begin
                stall_left <= 0;
                out_stall  <= 1'b0;
            end
            else
                stall_left <= stall_left - 1;
        end
    end

    // Every accepted result beat goes to the scoreboard. The ports are read
    // right at the edge, so these are the values the block presented.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ledger.check_layout('{aligned_width, aligned_height, stride, data_bytes,
                                  meta_size, byte_offset, total_size, is_last});
    end

    // Hang detection: any accepted beat on either channel restarts the count.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("hang: no beat accepted for %0d cycles", HANG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Offer one plane beat after a random gap and hold it until accepted.
    // Valid is only dropped when a gap follows, so back-to-back beats keep it
    // high without a glitch.
    task automatic drive_plane(input plane_t p);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid               <= 1'b1;
        plane_index            <= p.plane_index;
        pitch_align_log2       <= p.pitch_align_log2;
        height_align_log2      <= p.height_align_log2;
        meta_pitch_align_log2  <= p.meta_pitch_align_log2;
        meta_height_align_log2 <= p.meta_height_align_log2;
        meta_size_align_log2   <= p.meta_size_align_log2;
        blk_width              <= p.blk_width;
        blk_height             <= p.blk_height;
        last_plane             <= p.last_plane;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ledger.note_plane(p);
    endtask

    // Stop sending and let every outstanding result come back. Every plane
    // yields exactly one result, so an empty scoreboard means the block is idle.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // One register write. The enable is left high so that a run of writes
    // keeps it asserted; program_regs drops it afterwards.
    task automatic write_reg(input logic [2:0] idx, input logic [14:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        ledger.set_reg(idx, value);
    endtask

    task automatic program_regs(input logic [14:0] width_px, input logic [14:0] lines,
                                input logic [3:0] bpp, input logic comp,
                                input logic half, input logic [4:0] area_lg);
        write_reg(CFG_FRAME_WIDTH, width_px);
        write_reg(CFG_FRAME_HEIGHT, lines);
        write_reg(CFG_BYTES_PER_PIXEL, {11'd0, bpp});
        write_reg(CFG_COMPRESSED_MODE, {14'd0, comp});
        write_reg(CFG_HALF_HEIGHT, {14'd0, half});
        write_reg(CFG_SIZE_ALIGN_LG, {10'd0, area_lg});
        cfg_wr_en <= 1'b0;
    endtask

    function automatic plane_t plane_desc(int idx, int pa, int ha, int mpa, int mha,
                                          int msa, int bw, int bh, int last);
        plane_t p;
        p.plane_index            = 2'(idx);
        p.pitch_align_log2       = 4'(pa);
        p.height_align_log2      = 4'(ha);
        p.meta_pitch_align_log2  = 4'(mpa);
        p.meta_height_align_log2 = 4'(mha);
        p.meta_size_align_log2   = 5'(msa);
        p.blk_width              = 9'(bw);
        p.blk_height             = 9'(bh);
        p.last_plane             = 1'(last);
        return p;
    endfunction

    // Random plane content. Rough planes use the whole width of every field,
    // which reaches alignments past the usual range and zero block sizes.
    function automatic plane_t random_plane(int idx, int last, bit rough);
        if (rough)
            return plane_desc(idx, $urandom_range(0, 15), $urandom_range(0, 15),
                              $urandom_range(0, 15), $urandom_range(0, 15),
                              $urandom_range(0, 31), $urandom_range(0, 511),
                              $urandom_range(0, 511), last);
        return plane_desc(idx, $urandom_range(0, 12), $urandom_range(0, 12),
                          $urandom_range(0, 12), $urandom_range(0, 12),
                          $urandom_range(0, 16), $urandom_range(1, 256),
                          $urandom_range(1, 256), last);
    endfunction

    // Frame extent for a random setting: mostly the legal range, sometimes
    // its ends, sometimes anything the register can hold.
    function automatic logic [14:0] pick_extent();
        case ($urandom_range(0, 9))
            0: return 15'($urandom_range(0, 32767));
            1: return 15'd1;
            2: return 15'd16384;
            default: return 15'($urandom_range(1, 16384));
        endcase
    endfunction

    initial
    begin : stimulus
        int phase;
        int sent;
        int shape;
        int count;
        int k;

        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_index              = 3'd0;
        cfg_wdata              = 15'd0;
        in_valid               = 1'b0;
        plane_index            = 2'd0;
        pitch_align_log2       = 4'd0;
        height_align_log2      = 4'd0;
        meta_pitch_align_log2  = 4'd0;
        meta_height_align_log2 = 4'd0;
        meta_size_align_log2   = 5'd0;
        blk_width              = 9'd0;
        blk_height             = 9'd0;
        last_plane             = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: uncompressed 1920x1080, one byte per pixel,
        // 4 KiB plane alignment. A plain three-plane buffer.
        drive_plane(plane_desc(0, 0, 0, 0, 0, 0, 1, 1, 0));
        drive_plane(plane_desc(1, 6, 4, 12, 12, 16, 256, 256, 0));
        drive_plane(plane_desc(2, 12, 12, 3, 3, 3, 16, 16, 1));
        wait_for_idle();

        // Largest register values, half-height chroma and a 2 GiB size
        // alignment: alignment sums and products wrap at 32 bits.
        program_regs(15'd32767, 15'd32767, 4'd15, 1'b0, 1'b1, 5'd31);
        drive_plane(plane_desc(0, 15, 15, 0, 0, 0, 0, 0, 0));
        drive_plane(plane_desc(3, 15, 0, 15, 15, 31, 511, 511, 0));
        drive_plane(plane_desc(1, 0, 15, 0, 0, 0, 1, 1, 1));
        wait_for_idle();

        // Zero extents and zero bytes per pixel in compressed mode, with zero
        // block dimensions that must count as one.
        program_regs(15'd0, 15'd0, 4'd0, 1'b1, 1'b1, 5'd0);
        drive_plane(plane_desc(0, 0, 0, 0, 0, 0, 0, 0, 0));
        drive_plane(plane_desc(2, 0, 0, 15, 15, 31, 0, 511, 1));
        wait_for_idle();

        // Single-pixel frame against the largest blocks.
        program_regs(15'd1, 15'd1, 4'd1, 1'b1, 1'b0, 5'd16);
        drive_plane(plane_desc(0, 0, 0, 12, 12, 16, 511, 511, 0));
        drive_plane(plane_desc(1, 0, 0, 0, 0, 0, 1, 1, 1));
        wait_for_idle();

        // Largest legal frame, compressed, with one-pixel blocks giving the
        // biggest metadata planes. After a regular four-plane buffer comes a
        // buffer with its planes out of order.
        program_regs(15'd16384, 15'd16384, 4'd8, 1'b1, 1'b1, 5'd0);
        drive_plane(plane_desc(0, 0, 0, 12, 12, 16, 1, 1, 0));
        drive_plane(plane_desc(1, 0, 0, 6, 4, 12, 1, 0, 0));
        drive_plane(plane_desc(2, 0, 0, 0, 0, 0, 0, 1, 0));
        drive_plane(plane_desc(3, 0, 0, 15, 15, 31, 256, 256, 1));
        drive_plane(plane_desc(3, 3, 3, 5, 5, 5, 8, 8, 0));
        drive_plane(plane_desc(0, 3, 3, 5, 5, 5, 8, 8, 0));
        drive_plane(plane_desc(2, 3, 3, 5, 5, 5, 8, 8, 0));
        drive_plane(plane_desc(1, 3, 3, 5, 5, 5, 8, 8, 0));
        drive_plane(plane_desc(0, 3, 3, 5, 5, 5, 8, 8, 1));
        wait_for_idle();

        // Same frame uncompressed at the top of the usual alignment ranges.
        program_regs(15'd16384, 15'd16384, 4'd8, 1'b0, 1'b0, 5'd16);
        drive_plane(plane_desc(0, 12, 12, 0, 0, 0, 1, 1, 0));
        drive_plane(plane_desc(1, 0, 0, 0, 0, 0, 1, 1, 1));
        wait_for_idle();

        // Random part: sixteen settings of about a hundred planes each. Most
        // traffic is well-formed buffers of one to four planes in order with
        // the last one marked; some buffers lose their end mark, and some
        // carry random indices and marks. Now and then the sender drains the
        // block completely before going on.
        for (phase = 0; phase < 16; phase++)
        begin
            program_regs(pick_extent(), pick_extent(),
                         ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(1, 8)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(0, 16)));
            steady_flow = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < 100)
            begin
                shape = $urandom_range(0, 9);
                count = $urandom_range(1, 4);
                for (k = 0; k < count; k++)
                begin
                    if (shape == 0)
                        drive_plane(random_plane($urandom_range(0, 3), $urandom_range(0, 1),
                                                 $urandom_range(0, 7) == 0));
                    else if (shape == 1)
                        drive_plane(random_plane(k, 0, $urandom_range(0, 7) == 0));
                    else
                        drive_plane(random_plane(k, (k == count - 1),
                                                 $urandom_range(0, 7) == 0));
                end
                sent += count;
                if ($urandom_range(0, 30) == 0)
                    wait_for_idle();
            end
            wait_for_idle();
        end

        // Give the block time for any stray result beyond the last expected one.
        steady_flow = 1'b0;
        repeat (60) @(posedge clk);

        if (ledger.failures == 0 && ledger.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### plane_buffer_layout_calc_top.f
rtl/core/pblc_pkg.sv
rtl/core/pblc_div.sv
rtl/core/plane_buffer_layout_calc_top.sv
tb/tb_top.sv
